// File: hw/rtl/chi_pkg.sv
package chi_pkg;

  localparam int unsigned MaxTablesDefault    = 4;
  localparam int unsigned TableDepthDefault   = 1024;
  localparam int unsigned MaxFunctionsDefault = 4;
  localparam int unsigned QueueDepth          = 2;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned MultW = 31;
  localparam int unsigned ProdW = KeyW + MultW;
  localparam int unsigned CfgW  = 32;

  typedef enum logic [2:0] {
    CfgNumTables    = 3'd0,
    CfgNumFunctions = 3'd1,
    CfgTableSize    = 3'd2,
    CfgMaxLoop      = 3'd3,
    CfgMult0        = 3'd4,
    CfgMult1        = 3'd5,
    CfgMult2        = 3'd6,
    CfgMult3        = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StMul,
    StMod,
    StRead,
    StWait,
    StDecide,
    StOut,
    StClear
  } walk_state_e;

endpackage

// File: hw/rtl/chi_front.sv
module chi_front #(
  parameter int unsigned Depth = chi_pkg::QueueDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [chi_pkg::KeyW-1:0]  s_axis_tdata,
  output logic                      q_valid_o,
  input  logic                      q_pop_i,
  output logic [chi_pkg::KeyW-1:0]  q_key_o
);
  import chi_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [KeyW-1:0] mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]   cnt_q, cnt_d;
  logic            push;

  assign s_axis_tready = (cnt_q < (PtrW+1)'(Depth));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (cnt_q != '0);
  assign q_key_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= s_axis_tdata;
    end
  end

endmodule

// File: hw/rtl/chi_back.sv
module chi_back #(
  parameter int unsigned MaxTables    = chi_pkg::MaxTablesDefault,
  parameter int unsigned TableDepth   = chi_pkg::TableDepthDefault,
  parameter int unsigned MaxFunctions = chi_pkg::MaxFunctionsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [2:0]                cfg_index_i,
  input  logic [chi_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                      q_valid_i,
  output logic                      q_pop_o,
  input  logic [chi_pkg::KeyW-1:0]  q_key_i,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [55:0]               m_axis_tdata
);
  import chi_pkg::*;

  localparam int unsigned TblW  = (MaxTables > 1) ? $clog2(MaxTables) : 1;
  localparam int unsigned SlotW = $clog2(TableDepth);
  localparam int unsigned AddrW = TblW + SlotW;
  localparam int unsigned Words = MaxTables * TableDepth;
  localparam int unsigned RemW  = SlotW + 1;
  localparam int unsigned ModSteps = ProdW;

  logic [2:0]       num_tables_q, num_functions_q;
  logic [10:0]      table_size_q;
  logic [7:0]       max_loop_q;
  logic [MultW-1:0] mult_q [4];

  logic [KeyW-1:0] mem_q [Words];
  logic [KeyW-1:0] rdata_q;
  logic            we;
  logic [AddrW-1:0] addr;

  walk_state_e st_q, st_d;
  logic [KeyW-1:0]  carried_q, carried_d;
  logic [TblW-1:0]  tbl_q, tbl_d;
  logic [7:0]       cnt_q, cnt_d;
  logic [1:0]       fn_q, fn_d;
  logic [ProdW-1:0] prod_q, prod_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [5:0]       bit_q, bit_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [55:0]      out_q, out_d;

  logic [3:0]  nt;
  logic [2:0]  nf;
  logic [RemW-1:0] ts;
  logic [7:0]  ml;
  logic [RemW:0] sh;
  logic [MultW-1:0] msel;

  always_comb begin
    nt = (num_tables_q == 0) ? 4'd1 :
         ({1'b0, num_tables_q} > 4'(MaxTables)) ? 4'(MaxTables) : {1'b0, num_tables_q};
    nf = (num_functions_q == 0) ? 3'd1 :
         (num_functions_q > 3'(MaxFunctions)) ? 3'(MaxFunctions) : num_functions_q;
    ts = (table_size_q == 0) ? RemW'(1) :
         ({5'd0, table_size_q} > 16'(TableDepth)) ? RemW'(TableDepth) : RemW'(table_size_q);
    ml = (max_loop_q == 0) ? 8'd1 : max_loop_q;
    msel = mult_q[fn_q];
    sh = {rem_q, prod_q[6'(ProdW - 1) - bit_q]};
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_tables_q    <= 3'd2;
      num_functions_q <= 3'd2;
      table_size_q    <= 11'd1024;
      max_loop_q      <= 8'd16;
      mult_q[0] <= 31'd1;
      mult_q[1] <= 31'd3;
      mult_q[2] <= 31'd5;
      mult_q[3] <= 31'd7;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgNumTables:    num_tables_q    <= cfg_data_i[2:0];
        CfgNumFunctions: num_functions_q <= cfg_data_i[2:0];
        CfgTableSize:    table_size_q    <= cfg_data_i[10:0];
        CfgMaxLoop:      max_loop_q      <= cfg_data_i[7:0];
        CfgMult0:        mult_q[0]       <= cfg_data_i[MultW-1:0];
        CfgMult1:        mult_q[1]       <= cfg_data_i[MultW-1:0];
        CfgMult2:        mult_q[2]       <= cfg_data_i[MultW-1:0];
        CfgMult3:        mult_q[3]       <= cfg_data_i[MultW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    st_d = st_q; carried_d = carried_q; tbl_d = tbl_q; cnt_d = cnt_q;
    fn_d = fn_q; prod_d = prod_q; rem_d = rem_q; bit_d = bit_q;
    clr_d = clr_q; out_d = out_q;
    q_pop_o = 1'b0; we = 1'b0;
    addr = {tbl_q, rem_q[SlotW-1:0]};
    case (st_q)
      StClear: begin
        addr = clr_q; we = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == AddrW'(Words - 1)) st_d = StIdle;
      end
      StIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          carried_d = q_key_i; tbl_d = '0; cnt_d = '0; fn_d = '0;
          st_d = StMul;
        end
      end
      StMul: begin
        prod_d = ProdW'({32'd0, msel} * {31'd0, carried_q});
        rem_d = '0; bit_d = '0;
        st_d = StMod;
      end
      StMod: begin
        rem_d = (sh >= {1'b0, ts}) ? RemW'(sh - {1'b0, ts}) : RemW'(sh);
        bit_d = bit_q + 1'b1;
        if (bit_q == 6'(ModSteps - 1)) st_d = StRead;
      end
      StRead: st_d = StWait;
      StWait: st_d = StDecide;
      StDecide: begin
        if (rdata_q == '0) begin
          we = 1'b1;
          out_d = {3'd0, 32'd0, cnt_q, 10'(rem_q[SlotW-1:0]), 2'(tbl_q), 1'b0};
          st_d = StOut;
        end else if ({1'b0, cnt_q} + 9'd1 >= {1'b0, ml}) begin
          out_d = {3'd0, carried_q, cnt_q, 10'(rem_q[SlotW-1:0]), 2'(tbl_q), 1'b1};
          st_d = StOut;
        end else begin
          we = 1'b1;
          carried_d = rdata_q;
          tbl_d = ({1'b0, tbl_q} + 1'b1 >= (TblW+1)'(nt)) ? '0 : tbl_q + 1'b1;
          cnt_d = cnt_q + 1'b1;
          fn_d = ({1'b0, fn_q} + 1'b1 >= nf) ? '0 : fn_q + 1'b1;
          st_d = StMul;
        end
      end
      StOut: if (m_axis_tready) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[addr] <= (st_q == StClear) ? '0 : carried_q;
    rdata_q <= mem_q[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; clr_q <= '0;
      carried_q <= '0; tbl_q <= '0; cnt_q <= '0; fn_q <= '0;
      prod_q <= '0; rem_q <= '0; bit_q <= '0; out_q <= '0;
    end else begin
      st_q <= st_d; clr_q <= clr_d;
      carried_q <= carried_d; tbl_q <= tbl_d; cnt_q <= cnt_d; fn_q <= fn_d;
      prod_q <= prod_d; rem_q <= rem_d; bit_q <= bit_d; out_q <= out_d;
    end
  end

  assign m_axis_tvalid = (st_q == StOut);
  assign m_axis_tdata  = out_q;

endmodule

// File: hw/rtl/cuckoo_hash_insert_core.sv
// Each step of an eviction chain is one multiply, a bitwise restoring remainder of the 63-bit
// product against table_size, a registered memory read and a write unless the loop limit ends it.
// Keys are handled one at a time; the next is taken only after the result beat is accepted.
// After reset a clearing pass writes zero to all MAX_TABLES * TABLE_DEPTH words of the
// store; keys are queued meanwhile but processed only once it has finished.
module cuckoo_hash_insert_core #(
  parameter int unsigned MaxTables    = chi_pkg::MaxTablesDefault,
  parameter int unsigned TableDepth   = chi_pkg::TableDepthDefault,
  parameter int unsigned MaxFunctions = chi_pkg::MaxFunctionsDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [2:0]                cfg_index_i,
  input  logic [chi_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [31:0]               s_axis_tdata,  // key
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // status, final_table, final_slot, evictions, dropped_key
  output logic [55:0]               m_axis_tdata
);
  import chi_pkg::*;

  logic            q_valid, q_pop;
  logic [KeyW-1:0] q_key;

  chi_front u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_key_o(q_key)
  );

  chi_back #(
    .MaxTables(MaxTables), .TableDepth(TableDepth), .MaxFunctions(MaxFunctions)
  ) u_back (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_key_i(q_key),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

endmodule
